// ----- rtl/core/pid_filtered_derivative_defines.svh -----
// Assertion macros shared by the pid_filtered_derivative checkers.
// No dependencies; include by bare file name.
`ifndef PID_FILTERED_DERIVATIVE_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PFD_CHECK_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PFD_CHECK_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pfd: next-cycle check failed");

`endif

// ----- rtl/core/pfd_pkg.sv -----
// Shared types, constants and microcode table of the filtered-derivative PID.
// No dependencies; used by pfd_datapath and pid_filtered_derivative.
`timescale 1ns / 1ps

package pfd_pkg;

  // Sequencer step addresses
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_ERR      = 4'd1;
  localparam step_t STEP_WRAP     = 4'd2;
  localparam step_t STEP_UNWRAP   = 4'd3;
  localparam step_t STEP_SAT      = 4'd4;
  localparam step_t STEP_MUL_P    = 4'd5;
  localparam step_t STEP_MUL_I    = 4'd6;
  localparam step_t STEP_MUL_KD   = 4'd7;
  localparam step_t STEP_MUL_KF   = 4'd8;
  localparam step_t STEP_FILT_ADD = 4'd9;
  localparam step_t STEP_FILT_SAT = 4'd10;
  localparam step_t STEP_MUL_D    = 4'd11;
  localparam step_t STEP_SUM_D    = 4'd12;
  localparam step_t STEP_EMIT     = 4'd13;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_GAIN_P          = 3'd0;
  localparam cfg_index_t CFG_GAIN_I          = 3'd1;
  localparam cfg_index_t CFG_GAIN_D          = 3'd2;
  localparam cfg_index_t CFG_FILTER_WEIGHT   = 3'd3;
  localparam cfg_index_t CFG_INTEGRAL_LIMIT  = 3'd4;
  localparam cfg_index_t CFG_SETPOINT_OFFSET = 3'd5;
  localparam cfg_index_t CFG_ANGLE_WRAP      = 3'd6;

  // Fixed-point constants (Q16.16)
  localparam logic [16:0]        Q_ONE      = 17'd65536;
  localparam logic signed [33:0] HALF_TURN  = 34'sd11796480;
  localparam logic [35:0]        FULL_TURN  = 36'd23592960;
  // Offset that makes (error + half turn) non-negative: half turn + 512 full turns
  localparam logic [35:0]        WRAP_BIAS  = 36'd11796480 + (36'd23592960 << 9);
  // Highest shift of the full turn tried by the reduction loop
  localparam logic [3:0]         WRAP_TOP   = 4'd10;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P,
    MUL_I,
    MUL_KD,
    MUL_KF,
    MUL_D
  } mul_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_ERR,
    ALU_WRAP,
    ALU_UNWRAP,
    ALU_SAT,
    ALU_INTEG,
    ALU_FILT_LOAD,
    ALU_FILT_ADD,
    ALU_FILT_SAT
  } alu_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_WAIT_IN,
    JMP_IF_LINEAR,
    JMP_LOOP,
    JMP_EMIT
  } jmp_t;

  // One control word of the microprogram
  typedef struct packed {
    mul_sel_t mul;
    alu_op_t  alu;
    acc_op_t  acc;
    jmp_t     jmp;
    step_t    target;
  } uword_t;

  typedef struct packed {
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
    logic [16:0] filter_weight;
    logic [30:0] integral_limit;
    logic [31:0] setpoint_offset;
    logic        angle_wrap;
  } cfg_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic linear;
    logic loop_done;
  } status_t;

  typedef struct packed {
    logic [31:0] drive;
    logic        clamped;
  } result_t;

  // Saturate a signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Microprogram ROM
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w.mul    = MUL_NONE;
    w.alu    = ALU_NOP;
    w.acc    = ACC_HOLD;
    w.jmp    = JMP_NEXT;
    w.target = STEP_IDLE;
    unique case (s)
      STEP_IDLE: w.jmp = JMP_WAIT_IN;
      STEP_ERR: begin
        w.alu    = ALU_ERR;
        w.jmp    = JMP_IF_LINEAR;
        w.target = STEP_SAT;
      end
      STEP_WRAP: begin
        w.alu    = ALU_WRAP;
        w.jmp    = JMP_LOOP;
        w.target = STEP_WRAP;
      end
      STEP_UNWRAP:   w.alu = ALU_UNWRAP;
      STEP_SAT:      w.alu = ALU_SAT;
      STEP_MUL_P: begin
        w.mul = MUL_P;
        w.alu = ALU_INTEG;
      end
      STEP_MUL_I: begin
        w.mul = MUL_I;
        w.acc = ACC_LOAD;
      end
      STEP_MUL_KD: begin
        w.mul = MUL_KD;
        w.acc = ACC_ADD;
      end
      STEP_MUL_KF: begin
        w.mul = MUL_KF;
        w.alu = ALU_FILT_LOAD;
      end
      STEP_FILT_ADD: w.alu = ALU_FILT_ADD;
      STEP_FILT_SAT: w.alu = ALU_FILT_SAT;
      STEP_MUL_D:    w.mul = MUL_D;
      STEP_SUM_D:    w.acc = ACC_ADD;
      STEP_EMIT: begin
        w.jmp    = JMP_EMIT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/pfd_datapath.sv -----
// Datapath of the filtered-derivative PID: operand registers, one shared
// 33x33 multiplier, accumulators and loop state. Depends on pfd_pkg.
`timescale 1ns / 1ps

module pfd_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  pfd_pkg::uword_t        uw,
  input  logic                   in_take,
  input  logic signed [31:0]     target,
  input  logic signed [31:0]     measured,
  input  logic                   clear_integral,
  input  pfd_pkg::cfg_t          cfg,
  output pfd_pkg::status_t       st,
  output pfd_pkg::result_t       res
);

  // Captured input beat
  logic signed [31:0] tgt_q;
  logic signed [31:0] meas_q;
  logic               clr_q;

  // Working registers
  logic signed [33:0] err_wide;
  logic [35:0]        wrap_x;
  logic [3:0]         loop_cnt;
  logic signed [31:0] err;
  logic signed [32:0] diff;
  logic               clamped;
  logic signed [65:0] prod;
  logic signed [51:0] facc;
  logic signed [49:0] pid;

  // Controller state
  logic signed [31:0] integ;
  logic signed [31:0] frate;
  logic signed [31:0] prev_meas;

  logic signed [33:0] e34;
  logic [35:0]        wrap_sub;
  logic [16:0]        kb;
  logic [16:0]        kb_rest;
  logic signed [32:0] integ_sum;
  logic signed [32:0] lim;
  logic signed [31:0] integ_next;
  logic               clamp_hit;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] prod_hi;

  // Raw error and wrap helpers
  assign e34      = 34'(tgt_q) + 34'($signed(cfg.setpoint_offset)) - 34'(meas_q);
  assign wrap_sub = pfd_pkg::FULL_TURN << loop_cnt;
  assign kb       = cfg.filter_weight[16] ? pfd_pkg::Q_ONE : cfg.filter_weight;
  assign kb_rest  = pfd_pkg::Q_ONE - kb;
  assign prod_hi  = $signed(prod[65:16]);

  // Integral update with symmetric clamp
  always_comb begin
    integ_sum  = 33'(integ) + 33'(err);
    lim        = $signed({2'b00, cfg.integral_limit});
    integ_next = integ_sum[31:0];
    clamp_hit  = 1'b0;
    if (integ_sum > lim) begin
      integ_next = lim[31:0];
      clamp_hit  = 1'b1;
    end else if (integ_sum < -lim) begin
      integ_next = 32'(-lim);
      clamp_hit  = 1'b1;
    end
  end

  // Multiplier operand select
  always_comb begin
    unique case (uw.mul)
      pfd_pkg::MUL_P: begin
        mul_a = 33'(err);
        mul_b = $signed({1'b0, cfg.gain_p});
      end
      pfd_pkg::MUL_I: begin
        mul_a = 33'(integ);
        mul_b = $signed({1'b0, cfg.gain_i});
      end
      pfd_pkg::MUL_KD: begin
        mul_a = $signed({16'd0, kb});
        mul_b = diff;
      end
      pfd_pkg::MUL_KF: begin
        mul_a = $signed({16'd0, kb_rest});
        mul_b = 33'(frate);
      end
      pfd_pkg::MUL_D: begin
        mul_a = 33'(frate);
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Working registers, driven by the ALU field
  always_ff @(posedge clk) begin
    if (in_take) begin
      tgt_q  <= target;
      meas_q <= measured;
      clr_q  <= clear_integral;
    end
    unique case (uw.alu)
      pfd_pkg::ALU_ERR: begin
        err_wide <= e34;
        wrap_x   <= {{2{e34[33]}}, e34} + pfd_pkg::WRAP_BIAS;
        loop_cnt <= pfd_pkg::WRAP_TOP;
      end
      pfd_pkg::ALU_WRAP: begin
        // restoring reduction: one shifted full turn per step
        if (wrap_x >= wrap_sub) begin
          wrap_x <= wrap_x - wrap_sub;
        end
        loop_cnt <= loop_cnt - 4'd1;
      end
      pfd_pkg::ALU_UNWRAP: err_wide <= $signed({1'b0, wrap_x[32:0]}) - pfd_pkg::HALF_TURN;
      pfd_pkg::ALU_SAT: begin
        err  <= pfd_pkg::sat32(50'(err_wide));
        diff <= 33'(prev_meas) - 33'(meas_q);
      end
      pfd_pkg::ALU_INTEG:     clamped <= clamp_hit;
      pfd_pkg::ALU_FILT_LOAD: facc <= $signed(prod[51:0]);
      pfd_pkg::ALU_FILT_ADD:  facc <= facc + $signed(prod[51:0]);
      default: ;
    endcase
  end

  // P+I+D sum of floored products
  always_ff @(posedge clk) begin
    unique case (uw.acc)
      pfd_pkg::ACC_LOAD: pid <= prod_hi;
      pfd_pkg::ACC_ADD:  pid <= pid + prod_hi;
      default: ;
    endcase
  end

  // Controller state carried between samples
  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      frate     <= '0;
      prev_meas <= '0;
    end else begin
      unique case (uw.alu)
        pfd_pkg::ALU_ERR: begin
          if (clr_q) begin
            integ <= '0;
          end
        end
        pfd_pkg::ALU_SAT:      prev_meas <= meas_q;
        pfd_pkg::ALU_INTEG:    integ <= integ_next;
        pfd_pkg::ALU_FILT_SAT: frate <= pfd_pkg::sat32(50'($signed(facc[51:16])));
        default: ;
      endcase
    end
  end

  assign st.linear    = ~cfg.angle_wrap;
  assign st.loop_done = (loop_cnt == 4'd0);
  assign res.drive    = pfd_pkg::sat32(pid);
  assign res.clamped  = clamped;

endmodule

// ----- rtl/core/pid_filtered_derivative.sv -----
// PID controller with derivative on the measurement and a first-order
// low-pass on that derivative, all in signed Q16.16. One beat in gives one
// beat out. A microprogram drives one shared 33x33 multiplier, so a sample
// passes through its steps one after another from input beat to result. Only
// in angle mode is the error first reduced modulo a full turn, one shifted
// compare-and-subtract per cycle. The next input beat is taken
// once the sequencer is back at its first step; a finished result sits in the
// output register meanwhile, and the sequencer waits at its last step only if
// that register still holds an untaken result. Configuration writes are taken
// at any time through the plain write port but belong in idle periods.
// Depends on pfd_pkg and pfd_datapath.
`timescale 1ns / 1ps

module pid_filtered_derivative (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  input  logic               clear_integral,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] drive,
  output logic               integral_clamped
);

  pfd_pkg::cfg_t    cfg;
  pfd_pkg::step_t   pc;
  pfd_pkg::step_t   pc_next;
  pfd_pkg::step_t   pc_inc;
  pfd_pkg::uword_t  uw;
  pfd_pkg::status_t st;
  pfd_pkg::result_t res;
  logic             in_take;
  logic             out_free;
  logic             emit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p          <= '0;
      cfg.gain_i          <= '0;
      cfg.gain_d          <= '0;
      cfg.filter_weight   <= pfd_pkg::Q_ONE;
      cfg.integral_limit  <= '1;
      cfg.setpoint_offset <= '0;
      cfg.angle_wrap      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pfd_pkg::CFG_GAIN_P:          cfg.gain_p <= cfg_data;
        pfd_pkg::CFG_GAIN_I:          cfg.gain_i <= cfg_data;
        pfd_pkg::CFG_GAIN_D:          cfg.gain_d <= cfg_data;
        pfd_pkg::CFG_FILTER_WEIGHT:   cfg.filter_weight <= cfg_data[16:0];
        pfd_pkg::CFG_INTEGRAL_LIMIT:  cfg.integral_limit <= cfg_data[30:0];
        pfd_pkg::CFG_SETPOINT_OFFSET: cfg.setpoint_offset <= cfg_data;
        pfd_pkg::CFG_ANGLE_WRAP:      cfg.angle_wrap <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_stall = (pc != pfd_pkg::STEP_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Microprogram fetch
  assign uw     = pfd_pkg::ucode(pc);
  assign pc_inc = pc + 4'd1;
  assign emit   = (uw.jmp == pfd_pkg::JMP_EMIT) && out_free;

  // Next step
  always_comb begin
    unique case (uw.jmp)
      pfd_pkg::JMP_NEXT:      pc_next = pc_inc;
      pfd_pkg::JMP_GOTO:      pc_next = uw.target;
      pfd_pkg::JMP_WAIT_IN:   pc_next = in_take ? pc_inc : pc;
      pfd_pkg::JMP_IF_LINEAR: pc_next = st.linear ? uw.target : pc_inc;
      pfd_pkg::JMP_LOOP:      pc_next = st.loop_done ? pc_inc : uw.target;
      pfd_pkg::JMP_EMIT:      pc_next = out_free ? uw.target : pc;
      default:                pc_next = pfd_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pfd_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  pfd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .uw             (uw),
    .in_take        (in_take),
    .target         (target),
    .measured       (measured),
    .clear_integral (clear_integral),
    .cfg            (cfg),
    .st             (st),
    .res            (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      drive            <= $signed(res.drive);
      integral_clamped <= res.clamped;
    end
  end

endmodule

// ----- rtl/core/pfd_checker.sv -----
// Port-level checks for pid_filtered_derivative, attached by bind.
// Depends on pid_filtered_derivative_defines.svh.
`timescale 1ns / 1ps
`include "pid_filtered_derivative_defines.svh"

module pfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] drive,
  input logic        integral_clamped
);

  logic        in_take;
  logic        out_wait;
  logic [32:0] out_beat;

  assign in_take  = in_valid && !in_stall;
  assign out_wait = out_valid && out_stall;
  assign out_beat = {drive, integral_clamped};

  // A waiting result beat holds
  `PFD_CHECK_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(out_beat))

  // Nothing comes out right after reset
  `PFD_CHECK_SAME(a_reset_empty, clk, rst, $past(rst), !out_valid)

  // Once a sample is taken the block is busy for the next cycle
  `PFD_CHECK_NEXT(a_busy_after_take, clk, rst, in_take, in_stall)

  // No result can appear the cycle after a sample is taken
  `PFD_CHECK_NEXT(a_no_instant_result, clk, rst, in_take, !out_valid || $stable(out_beat))

endmodule

bind pid_filtered_derivative pfd_checker u_pfd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .drive            (drive),
  .integral_clamped (integral_clamped)
);

// ----- dv/pid_filtered_derivative_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for pid_filtered_derivative: tracks register writes and input beats,
// predicts every result beat and compares it field by field.
// Depends on pfd_pkg.

module pid_filtered_derivative_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  pfd_pkg::cfg_index_t cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic signed [31:0]  target,
  input  logic signed [31:0]  measured,
  input  logic                clear_integral,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [31:0]  drive,
  input  logic                integral_clamped,
  output int                  backlog,
  output int                  fail_count
);
  import pfd_pkg::*;

  localparam longint Q_UNITY  = 64'sd65536;
  localparam longint HALF_REV = 64'sd11796480;  // 180 degrees
  localparam longint FULL_REV = 64'sd23592960;  // 360 degrees
  localparam longint S32_HI   = 64'sd2147483647;
  localparam longint S32_LO   = -64'sd2147483648;

  // Register copies
  logic [31:0]        kp;
  logic [31:0]        ki;
  logic [31:0]        kd;
  logic [16:0]        kb_reg;
  logic [30:0]        int_limit;
  logic signed [31:0] sp_offset;
  logic               wrap_on;

  // Loop state
  logic signed [31:0] integ_sum;
  logic signed [31:0] filt_rate;
  logic signed [31:0] last_meas;

  result_t drive_due[$];
  result_t want;
  int      mismatches;

  function automatic longint clip32(input longint x);
    if (x > S32_HI) return S32_HI;
    if (x < S32_LO) return S32_LO;
    return x;
  endfunction

  // One control step: advances the loop state, returns drive and clamp flag
  function automatic result_t pid_update(input logic signed [31:0] tgt,
                                         input logic signed [31:0] meas,
                                         input logic clr);
    longint  err;
    longint  wrapped;
    longint  acc;
    longint  lim;
    longint  kb;
    longint  diff;
    longint  p_term;
    longint  i_term;
    longint  d_term;
    result_t r;
    r.clamped = 1'b0;
    // clear comes first, so the clamp flag only sees this step's error
    if (clr) integ_sum = '0;

    err = longint'(tgt) + longint'(sp_offset) - longint'(meas);
    if (wrap_on) begin
      wrapped = (err + HALF_REV) % FULL_REV;
      if (wrapped < 0) wrapped += FULL_REV;
      err = wrapped - HALF_REV;
    end
    err = clip32(err);
    p_term = (err * longint'(kp)) >>> 16;

    // integral with symmetric clamp
    lim = longint'(int_limit);
    acc = longint'(integ_sum) + err;
    if (acc > lim) begin
      acc = lim;
      r.clamped = 1'b1;
    end
    if (acc < -lim) begin
      acc = -lim;
      r.clamped = 1'b1;
    end
    integ_sum = 32'(acc);
    i_term = (acc * longint'(ki)) >>> 16;

    // low-pass on the measurement difference, weight capped at one
    kb = (kb_reg > 17'd65536) ? Q_UNITY : longint'(kb_reg);
    diff = longint'(last_meas) - longint'(meas);
    acc = (kb * diff + (Q_UNITY - kb) * longint'(filt_rate)) >>> 16;
    filt_rate = 32'(clip32(acc));
    d_term = (longint'(filt_rate) * longint'(kd)) >>> 16;
    last_meas = meas;

    r.drive = 32'(clip32(p_term + i_term + d_term));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp         = '0;
      ki         = '0;
      kd         = '0;
      kb_reg     = 17'd65536;
      int_limit  = '1;
      sp_offset  = '0;
      wrap_on    = 1'b0;
      integ_sum  = '0;
      filt_rate  = '0;
      last_meas  = '0;
      mismatches = 0;
      drive_due.delete();
    end else begin
      // register writes; index without a register is dropped
      if (cfg_write) begin
        case (cfg_index)
          CFG_GAIN_P:          kp = cfg_data;
          CFG_GAIN_I:          ki = cfg_data;
          CFG_GAIN_D:          kd = cfg_data;
          CFG_FILTER_WEIGHT:   kb_reg = cfg_data[16:0];
          CFG_INTEGRAL_LIMIT:  int_limit = cfg_data[30:0];
          CFG_SETPOINT_OFFSET: sp_offset = cfg_data;
          CFG_ANGLE_WRAP:      wrap_on = cfg_data[0];
          default: ;
        endcase
      end

      // result beat against oldest prediction
      if (out_valid && !out_stall) begin
        if (drive_due.size() == 0) begin
          mismatches++;
          $error("drive: no result expected, got %0d", drive);
        end else begin
          want = drive_due.pop_front();
          if (drive !== want.drive) begin
            mismatches++;
            $error("drive: expected %0d, got %0d", $signed(want.drive), drive);
          end
          if (integral_clamped !== want.clamped) begin
            mismatches++;
            $error("integral_clamped: expected %0b, got %0b", want.clamped,
                   integral_clamped);
          end
        end
      end

      // input beat
      if (in_valid && !in_stall) begin
        drive_due.push_back(pid_update(target, measured, clear_integral));
      end
    end
    backlog    <= drive_due.size();
    fail_count <= mismatches;
  end

endmodule

// ----- dv/tb_pid_filtered_derivative.sv -----
`timescale 1ns / 1ps
// Top of the pid_filtered_derivative testbench: clock, reset, register setup,
// directed and random samples with random idling, and the final verdict.
// Depends on pfd_pkg, pid_filtered_derivative and pid_filtered_derivative_checker.

module tb_pid_filtered_derivative;
  import pfd_pkg::*;

  localparam int                 LONG_HOLD   = 300;
  localparam int                 PHASES      = 12;
  localparam int                 PHASE_ITEMS = 136;
  localparam cfg_index_t         CFG_SPARE   = 3'd7;  // no register behind it
  localparam logic signed [31:0] S_MAX       = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S_MIN       = 32'sh80000000;
  localparam logic signed [31:0] DEG         = 32'sd65536;  // 1.0 in Q16.16

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  cfg_index_t         cfg_index = CFG_GAIN_P;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] target = '0;
  logic signed [31:0] measured = '0;
  logic               clear_integral = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] drive;
  logic               integral_clamped;
  int                 backlog;
  int                 fail_count;

  bit                 no_gaps = 1'b0;
  bit                 want_hold = 1'b0;
  logic signed [31:0] aim = '0;
  logic signed [31:0] pos = '0;

  pid_filtered_derivative dut (.*);
  pid_filtered_derivative_checker scoreboard (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stall before each beat, one long hold when asked
  initial begin : result_sink
    int unsigned hold;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (want_hold && !held) begin
        hold = LONG_HOLD;
        held = 1'b1;
      end else begin
        if (!want_hold) held = 1'b0;
        hold = no_gaps ? 0 : $urandom_range(0, 14);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic put(input cfg_index_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [31:0] gp, gi, gd, fw, lim, off,
                              input logic wrap_mode, input bit spare);
    if (spare) put(CFG_SPARE, $urandom());
    put(CFG_GAIN_P, gp);
    put(CFG_GAIN_I, gi);
    put(CFG_GAIN_D, gd);
    put(CFG_FILTER_WEIGHT, fw);
    put(CFG_INTEGRAL_LIMIT, lim);
    put(CFG_SETPOINT_OFFSET, off);
    // upper bits carry noise, only bit 0 counts
    put(CFG_ANGLE_WRAP, {31'($urandom()), wrap_mode});
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic random_setting();
    logic [31:0] fw;
    logic [31:0] lim;
    logic [31:0] off;
    case ($urandom_range(0, 5))
      0: fw = '0;
      1: fw = 32'd65536;
      2: fw = $urandom_range(65537, 131071);
      default: fw = $urandom_range(1, 65535);
    endcase
    if ($urandom_range(0, 3) == 0) fw[31:17] = 15'($urandom());
    case ($urandom_range(0, 5))
      0: lim = '0;
      1: lim = 32'h7FFF_FFFF;
      default: lim = $urandom_range(0, 32'h1000_0000);
    endcase
    lim[31] = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: off = S_MIN;
      1: off = S_MAX;
      2: off = '0;
      default: off = $signed($urandom()) >>> 7;
    endcase
    load_setting(pick_gain(), pick_gain(), pick_gain(), fw, lim, off,
                 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
  endtask

  // One input beat after a random gap
  task automatic offer(input logic signed [31:0] t, m, input logic c);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    target         <= t;
    measured       <= m;
    clear_integral <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every predicted result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic signed [31:0] t;
    logic signed [31:0] m;
    logic               c;
    bit                 pressure;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Linear mode, tight clamp: error saturation and clear against the clamp
    load_setting(32'h1_0000, 32'h4000, 32'h2_0000, 32'h8000, 32'h0010_0000, '0,
                 1'b0, 1'b1);
    offer(0, 0, 1'b0);
    offer(S_MAX, S_MIN, 1'b0);
    offer(S_MIN, S_MAX, 1'b0);
    offer(5 * DEG, 0, 1'b1);
    offer(20 * DEG, 0, 1'b1);
    offer(-3 * DEG, 2 * DEG, 1'b0);
    offer(S_MAX, S_MAX, 1'b0);
    offer(S_MIN, S_MIN, 1'b1);
    drain();

    // Weight above one, largest offset: filter saturates both ways
    load_setting(32'h8000, 32'h100, 32'h1_0000, 32'd131071, 32'h7FFF_FFFF, S_MAX,
                 1'b0, 1'b0);
    offer(0, S_MAX, 1'b0);
    offer(0, S_MIN, 1'b0);
    offer(0, S_MAX, 1'b0);
    offer(S_MAX, 0, 1'b0);
    offer(-1, 1, 1'b0);
    drain();

    // Angle mode with a 90 degree offset: both ends of the wrap range
    load_setting(32'h1_0000, 32'h800, 32'h4000, 32'h4000, 32'h0800_0000, 90 * DEG,
                 1'b1, 1'b0);
    offer(90 * DEG, 0, 1'b0);
    offer(-270 * DEG, 0, 1'b0);
    offer(0, 0, 1'b0);
    offer(S_MAX, S_MIN, 1'b0);
    offer(S_MIN, S_MAX, 1'b1);
    offer(200 * DEG, -300 * DEG, 1'b0);
    offer(-90 * DEG - 1, 0, 1'b0);
    drain();

    // Largest gains, zero limit, frozen filter, most negative offset
    load_setting('1, '1, '1, '0, '0, S_MIN, 1'b0, 1'b1);
    offer(0, 0, 1'b0);
    offer(S_MAX, S_MIN, 1'b1);
    offer(S_MIN, S_MAX, 1'b0);
    offer(12345, -999, 1'b0);
    drain();

    // Random phases; two of them run back to back against a long result hold
    for (int ph = 0; ph < PHASES; ph++) begin
      random_setting();
      pressure  = (ph == 2) || (ph == 8);
      want_hold = pressure;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 34 == 0) no_gaps = pressure || ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 7) begin
          // slow trajectory toward an occasionally moving setpoint
          if ($urandom_range(0, 19) == 0) aim = $signed($urandom()) >>> 6;
          pos = pos + ($signed($urandom()) >>> 14);
          t = aim;
          m = pos;
        end else begin
          t = $urandom();
          m = $urandom();
          case ($urandom_range(0, 3))
            0: t = S_MAX;
            1: m = S_MIN;
            2: m = pos;
            default: ;
          endcase
        end
        c = ($urandom_range(0, 11) == 0);
        offer(t, m, c);
      end
      want_hold = 1'b0;
      drain();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
